FILE: rtl/spct_pkg.sv
// Package for the shape pair collision test: default sizes and shape-pair mode codes.
`timescale 1ns / 1ps
package spct_pkg;

	localparam int COORD_BITS       = 24;
	localparam int NORMAL_FRAC_BITS = 14;

	// shape kind as carried in the item
	localparam logic SHAPE_BOX    = 1'b0;
	localparam logic SHAPE_CIRCLE = 1'b1;

	// pair mode
	localparam logic [1:0] MODE_BB = 2'd0;
	localparam logic [1:0] MODE_CC = 2'd1;
	localparam logic [1:0] MODE_CB = 2'd2;

endpackage

FILE: rtl/shape_pair_collision_test.sv
// Shape pair collision test: box/circle overlap with a pipelined unit-normal search.
//
// channel | dir | fields (lowest bit first)
// s_*     | in  | a_shape a_x a_y a_w a_h b_shape b_x b_y b_w b_h
// m_*     | out | hit normal_x normal_y
//
// One item enters per cycle while the output is not stalled; the pipeline length is set by the
// bit-per-stage search for each normal component (one stage per result bit).
// arst_n clears only the valid bits; payload registers are not reset.
// The whole pipeline advances together: when the output holds an item that
// m_tready does not take, every stage holds and s_tready drops.
`timescale 1ns / 1ps
module shape_pair_collision_test #(
	parameter int COORD_BITS       = spct_pkg::COORD_BITS,
	parameter int NORMAL_FRAC_BITS = spct_pkg::NORMAL_FRAC_BITS,
	localparam int IN_W  = ((8*COORD_BITS - 2 + 7) / 8) * 8,
	localparam int OUT_W = ((2*(NORMAL_FRAC_BITS + 2) + 1 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// a_shape, a_x, a_y, a_w, a_h, b_shape, b_x, b_y, b_w, b_h, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// hit, normal_x, normal_y, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	localparam int C   = COORD_BITS;
	localparam int F   = NORMAL_FRAC_BITS;
	localparam int NW  = F + 2;
	localparam int DW  = 2*C - 2;
	localparam int VW  = 2*F + 2*C + 2;
	localparam int NS  = F + 1;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- unpack ----------------
	logic                sa, sb;
	logic signed [C-1:0] ax, ay, bx, by;
	logic [C-2:0]        aw, ah, bw, bh;
	assign sa = s_tdata[0];
	assign ax = s_tdata[C:1];
	assign ay = s_tdata[2*C:C+1];
	assign aw = s_tdata[3*C-1:2*C+1];
	assign ah = s_tdata[4*C-2:3*C];
	assign sb = s_tdata[4*C-1];
	assign bx = s_tdata[5*C-1:4*C];
	assign by = s_tdata[6*C-1:5*C];
	assign bw = s_tdata[7*C-2:6*C];
	assign bh = s_tdata[8*C-3:7*C-1];

	// ---------------- stage 1: box test, role select ----------------
	logic signed [C:0] axe, aye, bxe, bye, awe, ahe, bwe, bhe;
	logic [1:0]        mode_c;
	logic              bb_c;
	assign axe = {ax[C-1], ax};
	assign aye = {ay[C-1], ay};
	assign bxe = {bx[C-1], bx};
	assign bye = {by[C-1], by};
	assign awe = {2'b00, aw};
	assign ahe = {2'b00, ah};
	assign bwe = {2'b00, bw};
	assign bhe = {2'b00, bh};
	assign bb_c = (axe < bxe + bwe) && (axe + awe > bxe) &&
		(aye < bye + bhe) && (aye + ahe > bye);

	always_comb begin
		if (sa == spct_pkg::SHAPE_CIRCLE && sb == spct_pkg::SHAPE_CIRCLE) begin
			mode_c = spct_pkg::MODE_CC;
		end else if (sa == spct_pkg::SHAPE_BOX && sb == spct_pkg::SHAPE_BOX) begin
			mode_c = spct_pkg::MODE_BB;
		end else begin
			mode_c = spct_pkg::MODE_CB;
		end
	end

	logic              v_s1, bb_s1;
	logic [1:0]        mode_s1;
	logic [C-1:0]      sum_s1;
	logic signed [C:0] dxc_s1, dyc_s1, cx_s1, cy_s1, qx_s1, qy_s1, qx2_s1, qy2_s1;
	logic [C-2:0]      r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_c;
			bb_s1   <= bb_c;
			sum_s1  <= {1'b0, aw} + {1'b0, bw};
			dxc_s1  <= axe - bxe;
			dyc_s1  <= aye - bye;
			// circle first unless the first shape is the box
			cx_s1   <= sa ? axe : bxe;
			cy_s1   <= sa ? aye : bye;
			r_s1    <= sa ? aw : bw;
			qx_s1   <= sa ? bxe : axe;
			qy_s1   <= sa ? bye : aye;
			qx2_s1  <= sa ? bxe + bwe : axe + awe;
			qy2_s1  <= sa ? bye + bhe : aye + ahe;
		end
	end

	// ---------------- stage 2: clamp, circle distances ----------------
	logic signed [C:0]   clx, cly;
	logic signed [C+1:0] dx_c, dy_c;
	logic [C:0]          adxc_c, adyc_c;
	assign clx  = (cx_s1 < qx_s1) ? qx_s1 : ((cx_s1 > qx2_s1) ? qx2_s1 : cx_s1);
	assign cly  = (cy_s1 < qy_s1) ? qy_s1 : ((cy_s1 > qy2_s1) ? qy2_s1 : cy_s1);
	assign dx_c = {cx_s1[C], cx_s1} - {clx[C], clx};
	assign dy_c = {cy_s1[C], cy_s1} - {cly[C], cly};
	assign adxc_c = dxc_s1[C] ? (C+1)'(-dxc_s1) : dxc_s1;
	assign adyc_c = dyc_s1[C] ? (C+1)'(-dyc_s1) : dyc_s1;

	logic                v_s2, bb_s2, inrc_s2;
	logic [1:0]          mode_s2;
	logic [C-1:0]        sum_s2, adxc_s2, adyc_s2;
	logic signed [C+1:0] dx_s2, dy_s2;
	logic [C-2:0]        r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			bb_s2   <= bb_s1;
			sum_s2  <= sum_s1;
			inrc_s2 <= (adxc_c <= {1'b0, sum_s1}) && (adyc_c <= {1'b0, sum_s1});
			adxc_s2 <= adxc_c[C-1:0];
			adyc_s2 <= adyc_c[C-1:0];
			dx_s2   <= dx_c;
			dy_s2   <= dy_c;
			r_s2    <= r_s1;
		end
	end

	// ---------------- stage 3: circle squares, box offsets ----------------
	logic [C+1:0] adxb_c, adyb_c;
	assign adxb_c = dx_s2[C+1] ? (C+2)'(-dx_s2) : dx_s2;
	assign adyb_c = dy_s2[C+1] ? (C+2)'(-dy_s2) : dy_s2;

	logic           v_s3, bb_s3, inrc_s3, inrb_s3, negx_s3, negy_s3;
	logic [1:0]     mode_s3;
	logic [2*C-1:0] sqx_s3, sqy_s3, sqs_s3;
	logic [C-2:0]   adxb_s3, adyb_s3, r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			bb_s3   <= bb_s2;
			inrc_s3 <= inrc_s2;
			sqx_s3  <= adxc_s2 * adxc_s2;
			sqy_s3  <= adyc_s2 * adyc_s2;
			sqs_s3  <= sum_s2 * sum_s2;
			inrb_s3 <= (adxb_c < {3'b000, r_s2}) && (adyb_c < {3'b000, r_s2});
			negx_s3 <= dx_s2[C+1];
			negy_s3 <= dy_s2[C+1];
			adxb_s3 <= adxb_c[C-2:0];
			adyb_s3 <= adyb_c[C-2:0];
			r_s3    <= r_s2;
		end
	end

	// ---------------- stage 4: circle compare, box squares ----------------
	logic          v_s4, bb_s4, cch_s4, inrb_s4, negx_s4, negy_s4;
	logic [1:0]    mode_s4;
	logic [DW-1:0] tx_s4, ty_s4, rr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_s3;
			bb_s4   <= bb_s3;
			cch_s4  <= inrc_s3 &&
				({1'b0, sqx_s3} + {1'b0, sqy_s3} <= {1'b0, sqs_s3});
			inrb_s4 <= inrb_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			tx_s4   <= adxb_s3 * adxb_s3;
			ty_s4   <= adyb_s3 * adyb_s3;
			rr_s4   <= r_s3 * r_s3;
		end
	end

	// ---------------- stage 5: distance, final hit ----------------
	logic [DW:0] d2_c;
	logic        cbh_c, hit_c;
	assign d2_c  = {1'b0, tx_s4} + {1'b0, ty_s4};
	assign cbh_c = inrb_s4 && (d2_c < {1'b0, rr_s4});

	always_comb begin
		case (mode_s4)
			spct_pkg::MODE_BB: hit_c = bb_s4;
			spct_pkg::MODE_CC: hit_c = cch_s4;
			spct_pkg::MODE_CB: hit_c = cbh_c;
			default:           hit_c = 1'b0;
		endcase
	end

	// search lanes, index 0 is the stage 5 register
	logic          v_p    [0:NS];
	logic [1:0]    mode_p [0:NS];
	logic          hit_p  [0:NS];
	logic          zero_p [0:NS];
	logic          negx_p [0:NS];
	logic          negy_p [0:NS];
	logic [DW-1:0] d2_p   [0:NS];
	logic [DW-1:0] tx_p   [0:NS];
	logic [DW-1:0] ty_p   [0:NS];
	logic [F:0]    nx_p   [0:NS];
	logic [F:0]    ny_p   [0:NS];
	logic [VW-1:0] ax_p   [0:NS];
	logic [VW-1:0] bx_p   [0:NS];
	logic [VW-1:0] ay_p   [0:NS];
	logic [VW-1:0] by_p   [0:NS];

	// trial per search stage: n' = n + 2^k, keep A = n^2*d2 and B = n*d2
	logic [VW-1:0] tax [0:NS-1];
	logic [VW-1:0] tbx [0:NS-1];
	logic [VW-1:0] tay [0:NS-1];
	logic [VW-1:0] tby [0:NS-1];
	logic          okx [0:NS-1];
	logic          oky [0:NS-1];

	always_comb begin
		for (int j = 0; j < NS; j++) begin
			tax[j] = ax_p[j] + (bx_p[j] << (F - j + 1)) + (VW'(d2_p[j]) << (2*(F - j)));
			tbx[j] = bx_p[j] + (VW'(d2_p[j]) << (F - j));
			tay[j] = ay_p[j] + (by_p[j] << (F - j + 1)) + (VW'(d2_p[j]) << (2*(F - j)));
			tby[j] = by_p[j] + (VW'(d2_p[j]) << (F - j));
			// (2n'-1)^2 * d2 <= ad^2 * 2^(2F+2)
			okx[j] = ((tax[j] << 2) - (tbx[j] << 2) + VW'(d2_p[j])) <=
				(VW'(tx_p[j]) << (2*F + 2));
			oky[j] = ((tay[j] << 2) - (tby[j] << 2) + VW'(d2_p[j])) <=
				(VW'(ty_p[j]) << (2*F + 2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NS; j++) begin
				v_p[j] <= 1'b0;
			end
		end else if (en) begin
			v_p[0] <= v_s4;
			for (int j = 0; j < NS; j++) begin
				v_p[j+1] <= v_p[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_p[0] <= mode_s4;
			hit_p[0]  <= hit_c;
			zero_p[0] <= (d2_c == '0);
			negx_p[0] <= negx_s4;
			negy_p[0] <= negy_s4;
			d2_p[0]   <= d2_c[DW-1:0];
			tx_p[0]   <= tx_s4;
			ty_p[0]   <= ty_s4;
			nx_p[0]   <= '0;
			ny_p[0]   <= '0;
			ax_p[0]   <= '0;
			bx_p[0]   <= '0;
			ay_p[0]   <= '0;
			by_p[0]   <= '0;
			for (int j = 0; j < NS; j++) begin
				mode_p[j+1] <= mode_p[j];
				hit_p[j+1]  <= hit_p[j];
				zero_p[j+1] <= zero_p[j];
				negx_p[j+1] <= negx_p[j];
				negy_p[j+1] <= negy_p[j];
				d2_p[j+1]   <= d2_p[j];
				tx_p[j+1]   <= tx_p[j];
				ty_p[j+1]   <= ty_p[j];
				nx_p[j+1]   <= okx[j] ? (nx_p[j] | ((F+1)'(1) << (F - j))) : nx_p[j];
				ax_p[j+1]   <= okx[j] ? tax[j] : ax_p[j];
				bx_p[j+1]   <= okx[j] ? tbx[j] : bx_p[j];
				ny_p[j+1]   <= oky[j] ? (ny_p[j] | ((F+1)'(1) << (F - j))) : ny_p[j];
				ay_p[j+1]   <= oky[j] ? tay[j] : ay_p[j];
				by_p[j+1]   <= oky[j] ? tby[j] : by_p[j];
			end
		end
	end

	// ---------------- output register ----------------
	logic                 hit_q;
	logic signed [NW-1:0] nx_q, ny_q, nx_c, ny_c;
	logic signed [NW-1:0] magx, magy;
	assign magx = {1'b0, nx_p[NS]};
	assign magy = {1'b0, ny_p[NS]};

	always_comb begin
		nx_c = '0;
		ny_c = '0;
		if (mode_p[NS] == spct_pkg::MODE_CB && hit_p[NS]) begin
			if (zero_p[NS]) begin
				ny_c = -(NW'(1) << F);
			end else begin
				nx_c = negx_p[NS] ? -magx : magx;
				ny_c = negy_p[NS] ? -magy : magy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_p[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_p[NS];
			nx_q  <= nx_c;
			ny_q  <= ny_c;
		end
	end

	assign m_tdata = OUT_W'({ny_q, nx_q, hit_q});

	// ---------------- checks ----------------
	a_normal_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (nx_q != '0 || ny_q != '0) |-> hit_q)
		else $error("normal without hit");

	a_normal_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (nx_q <= (NW'(1) << F)) && (nx_q >= -(NW'(1) << F)))
		else $error("normal_x out of range");

	a_normal_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ny_q <= (NW'(1) << F)) && (ny_q >= -(NW'(1) << F)))
		else $error("normal_y out of range");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_p[NS]) && $stable(v_s1))
		else $error("pipeline moved during stall");

endmodule

FILE: tb/sv/spct_checker.sv
// Checker for the shape pair collision test: predicts each result and compares it.
`timescale 1ns / 1ps
module spct_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	output int           fails,
	output int           pending
);

	localparam int F = spct_pkg::NORMAL_FRAC_BITS;

	// packed from the lowest bit up: hit, nx, ny
	typedef struct packed {
		logic signed [15:0] ny;
		logic signed [15:0] nx;
		logic               hit;
	} contact_t;

	contact_t contact_q[$];

	function automatic longint coord(logic [23:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	// rounded |d| * 2^F / sqrt(d2), found by bisection on the half-step boundary
	function automatic longint unit_mag(longint ad, longint d2);
		logic [127:0] goal;
		logic [127:0] lhs;
		longint lo;
		longint hi;
		longint mid;
		longint m;
		goal = (128'(ad) * 128'(ad)) << (2 * F + 2);
		lo = 0;
		hi = longint'(1) << F;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			m = 2 * mid - 1;
			lhs = 128'(m * m) * 128'(d2);
			if (lhs <= goal) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic contact_t collide(logic [191:0] d);
		contact_t r;
		logic sa;
		logic sb;
		longint ax, ay, aw, ah, bx, by, bw, bh;
		longint cx, cy, rad, qx, qy, qw, qh, dx, dy, s, d2;
		sa = d[0];
		ax = coord(d[24:1]);
		ay = coord(d[48:25]);
		aw = longint'(d[71:49]);
		ah = longint'(d[94:72]);
		sb = d[95];
		bx = coord(d[119:96]);
		by = coord(d[143:120]);
		bw = longint'(d[166:144]);
		bh = longint'(d[189:167]);
		r = '0;
		if (sa == spct_pkg::SHAPE_BOX && sb == spct_pkg::SHAPE_BOX) begin
			r.hit = ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
		end else if (sa == spct_pkg::SHAPE_CIRCLE && sb == spct_pkg::SHAPE_CIRCLE) begin
			s = aw + bw;
			dx = absl(ax - bx);
			dy = absl(ay - by);
			r.hit = dx <= s && dy <= s && dx * dx + dy * dy <= s * s;
		end else begin
			if (sa == spct_pkg::SHAPE_CIRCLE) begin
				cx = ax; cy = ay; rad = aw; qx = bx; qy = by; qw = bw; qh = bh;
			end else begin
				cx = bx; cy = by; rad = bw; qx = ax; qy = ay; qw = aw; qh = ah;
			end
			dx = cx - clamp(cx, qx, qx + qw);
			dy = cy - clamp(cy, qy, qy + qh);
			if (absl(dx) < rad && absl(dy) < rad) begin
				d2 = dx * dx + dy * dy;
				if (d2 < rad * rad) begin
					r.hit = 1'b1;
					if (d2 == 0) begin
						r.ny = -(16'sd1 <<< F);
					end else begin
						r.nx = 16'(unit_mag(absl(dx), d2));
						r.ny = 16'(unit_mag(absl(dy), d2));
						if (dx < 0) r.nx = -r.nx;
						if (dy < 0) r.ny = -r.ny;
					end
				end
			end
		end
		return r;
	endfunction

	assign pending = contact_q.size();

	always @(posedge clk or negedge arst_n) begin
		contact_t want;
		contact_t got;
		if (!arst_n) begin
			fails <= 0;
		end else begin
			if (s_tvalid && s_tready)
				contact_q.push_back(collide(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[32:0];
				if (contact_q.size() == 0) begin
					$display("%0t: unexpected item, actual %h", $time, got);
					fails <= fails + 1;
				end else begin
					want = contact_q.pop_front();
					if (got.hit !== want.hit || got.nx !== want.nx || got.ny !== want.ny) begin
						$display("%0t: mismatch, expected hit %0d nx %0d ny %0d, actual hit %0d nx %0d ny %0d",
							$time, want.hit, want.nx, want.ny, got.hit, got.nx, got.ny);
						fails <= fails + 1;
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb_shape_pair_collision_test.sv
// Testbench top for the shape pair collision test: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_shape_pair_collision_test;

	localparam int LIMIT = 400000;
	localparam logic BOX = spct_pkg::SHAPE_BOX;
	localparam logic CIR = spct_pkg::SHAPE_CIRCLE;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	int           fails;
	int           pending;
	int           cycles = 0;
	bit           busy_phase = 1'b1;

	always #1 clk = ~clk;

	shape_pair_collision_test u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	spct_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fails(fails), .pending(pending)
	);

	function automatic int gap_len();
		if (!busy_phase) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
		return $urandom_range(0, 2);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stall stretches
	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			m_tready <= 1'b1;
			n = $urandom_range(1, 12);
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send(logic as_, logic [23:0] ax, logic [23:0] ay, logic [22:0] aw,
			logic [22:0] ah, logic bs, logic [23:0] bx, logic [23:0] by,
			logic [22:0] bw, logic [22:0] bh);
		int n;
		s_tdata <= {2'b00, bh, bw, by, bx, bs, ah, aw, ay, ax, as_};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n = gap_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [22:0] rand_size();
		int k;
		k = $urandom_range(0, 23);
		return 23'($urandom & ((32'd1 << k) - 1));
	endfunction

	initial begin
		logic as_, bs;
		logic [23:0] ax, ay, bx, by;
		logic [22:0] aw, ah, bw, bh;
		int k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// box pairs at the coordinate extremes, touching edges, empty boxes
		send(BOX, 24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff,
			BOX, 24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff);
		send(BOX, 24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff,
			BOX, 24'hffffff, 24'hffffff, 23'h0, 23'h0);
		send(BOX, 24'd0, 24'd0, 23'd256, 23'd256, BOX, 24'd256, 24'd0, 23'd256, 23'd256);
		send(BOX, 24'd0, 24'd0, 23'd256, 23'd256, BOX, 24'd255, 24'd255, 23'd1, 23'd1);
		send(BOX, 24'd10, 24'd10, 23'd0, 23'd0, BOX, 24'd0, 24'd0, 23'd20, 23'd20);
		// circles: zero radii coincident and apart, exactly touching, far extremes
		send(CIR, 24'd5, 24'd5, 23'd0, 23'd0, CIR, 24'd5, 24'd5, 23'd0, 23'd0);
		send(CIR, 24'd5, 24'd5, 23'd0, 23'd0, CIR, 24'd6, 24'd5, 23'd0, 23'd0);
		send(CIR, 24'd0, 24'd0, 23'd300, 23'h7fffff, CIR, 24'd300, 24'd400, 23'd200, 23'd0);
		send(CIR, 24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff,
			CIR, 24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff);
		// circle against box: centre inside, zero radius, both orders, empty box, diagonal
		send(CIR, 24'd50, 24'd50, 23'd10, 23'd0, BOX, 24'd0, 24'd0, 23'd100, 23'd100);
		send(BOX, 24'd0, 24'd0, 23'd100, 23'd100, CIR, 24'd50, 24'd50, 23'd10, 23'd0);
		send(CIR, 24'd50, 24'd50, 23'd0, 23'd0, BOX, 24'd0, 24'd0, 23'd100, 23'd100);
		send(CIR, 24'd105, 24'd50, 23'd10, 23'd0, BOX, 24'd0, 24'd0, 23'd100, 23'd100);
		send(BOX, 24'd0, 24'd0, 23'd100, 23'd100, CIR, 24'hfffffb, 24'd50, 23'd10, 23'd0);
		send(CIR, 24'd50, 24'hfffff9, 23'd10, 23'd0, BOX, 24'd0, 24'd0, 23'd100, 23'd100);
		send(CIR, 24'd104, 24'd103, 23'd10, 23'd0, BOX, 24'd0, 24'd0, 23'd100, 23'd100);
		send(CIR, 24'd110, 24'd50, 23'd10, 23'd0, BOX, 24'd0, 24'd0, 23'd100, 23'd100);
		send(CIR, 24'd3, 24'd4, 23'd6, 23'd0, BOX, 24'd0, 24'd0, 23'd0, 23'd0);
		send(CIR, 24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff,
			BOX, 24'h800000, 24'h800000, 23'h7fffff, 23'h7fffff);
		send(BOX, 24'h800000, 24'h800000, 23'h0, 23'h0,
			CIR, 24'h7fffff, 24'h800000, 23'h7fffff, 23'h0);

		for (int i = 0; i < 1200; i++) begin
			if (i % 200 == 0) busy_phase = (i / 200) % 3 != 1;
			as_ = 1'($urandom_range(0, 1));
			bs = 1'($urandom_range(0, 1));
			ax = 24'($urandom);
			ay = 24'($urandom);
			aw = rand_size();
			ah = rand_size();
			bw = rand_size();
			bh = rand_size();
			if ($urandom_range(0, 5) == 0) begin
				bx = 24'($urandom);
				by = 24'($urandom);
				aw = 23'($urandom);
				ah = 23'($urandom);
				bw = 23'($urandom);
				bh = 23'($urandom);
			end else begin
				// place the second shape near the first so that hits are common
				k = $urandom_range(0, 23);
				bx = ax + 24'($signed($urandom) >>> (31 - k));
				by = ay + 24'($signed($urandom) >>> (31 - k));
			end
			send(as_, ax, ay, aw, ah, bs, bx, by, bw, bh);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
